@@ rtl/dsts_pkg.sv @@
// Shared types and constants for the data server table steering block.
// No dependencies; imported by the top level, the modulo unit and the testbench.
package dsts_pkg;

    // Table geometry
    localparam int MAX_DEVICES = 16;
    localparam int IDX_W       = 4;    // bits to address one table entry
    localparam int CNT_W       = 5;    // bits to hold a count up to MAX_DEVICES
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 8;
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int CTR_W       = 32;

    // Device ids are 'D','S', zeros, then index+1 in the last byte
    localparam logic [KEY_W-1:0] ID_PREFIX = 64'h4453_0000_0000_0000;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER = 3'd0,
        REQ_SET_ROOT = 3'd1,
        REQ_STEER    = 3'd2,
        REQ_CHECK    = 3'd3,
        REQ_FIND     = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_IGNORED = 2'd1,
        STATUS_NONE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN
    } t_state;

    // Result of the serial modulo unit
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } t_mod_res;

endpackage

@@ rtl/data_server_table_steering_top.sv @@
// Top level of the data server table: request sequencer, table storage and result register.
// Depends on dsts_pkg and dsts_mod_unit.
//
//   channel   handshake                 payload
//   request   i_in_valid / o_in_ready   i_req_type, i_entry_index, i_handle_length,
//                                       i_mount_key, i_device_id_high, i_device_id_low
//   result    o_out_valid / i_out_ready o_status, o_result_index, o_backing_hit,
//                                       o_entries_used, o_service_active
//   config    i_cfg_valid / o_cfg_ready i_cfg_feature_on
//
// Register, set root, undefined and early-out requests raise o_out_valid at the transfer edge.
// Check and find scan one entry per cycle through a shared compare.
// Steer with the gate on and servers present runs the 32-step serial modulo of the counter
// by the entry count, loads the start, then scans one entry per cycle.
// One request at a time; ready returns in the cycle after the result transfer.
// Reset is synchronous: table empty, counter zero, feature off. No clearing pass.
module data_server_table_steering_top #(
    parameter int MOUNT_ID_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dsts_pkg::REQ_W-1:0]    i_req_type,
    input  logic [dsts_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [dsts_pkg::LEN_W-1:0]    i_handle_length,
    input  logic [dsts_pkg::KEY_W-1:0]    i_mount_key,
    input  logic [dsts_pkg::KEY_W-1:0]    i_device_id_high,
    input  logic [dsts_pkg::KEY_W-1:0]    i_device_id_low,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dsts_pkg::STATUS_W-1:0] o_status,
    output logic [dsts_pkg::IDX_W-1:0]    o_result_index,
    output logic                          o_backing_hit,
    output logic [dsts_pkg::CNT_W-1:0]    o_entries_used,
    output logic                          o_service_active,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_feature_on
);
    import dsts_pkg::*;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * MOUNT_ID_BYTES);
    localparam logic [LEN_W-1:0] LONG_LEN = LEN_W'(MOUNT_ID_BYTES);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_DEVICES);

    // Control state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CTR_W-1:0]       r_counter, n_counter;
    logic [MAX_DEVICES-1:0] r_ready;
    logic [MAX_DEVICES-1:0] r_long;
    logic                   r_feature;
    logic                   r_out_valid, n_out_valid;

    // Payload state
    logic [KEY_W-1:0]       r_keys [MAX_DEVICES];
    logic [REQ_W-1:0]       r_req;
    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       r_idl;
    logic [IDX_W-1:0]       r_k, n_k;
    logic [CNT_W-1:0]       r_i, n_i;
    logic [CTR_W-1:0]       r_sum, n_sum;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [IDX_W-1:0]       r_rindex, n_rindex;
    logic                   r_hit, n_hit;
    logic [CNT_W-1:0]       r_used, n_used;
    logic                   r_active, n_active;

    // Decode
    logic                   w_accept;
    logic                   w_steer_ok;
    logic                   w_go_check;
    logic                   w_go_find;
    logic                   w_reg_ok;
    logic                   w_set_ok;
    logic                   w_mod_start;
    t_mod_res               w_mod;

    // Scan datapath
    logic [IDX_W-1:0]       w_sel;
    logic [KEY_W-1:0]       w_cmp_a;
    logic [KEY_W-1:0]       w_cmp_b;
    logic [KEY_W-1:0]       w_cmp_m;
    logic                   w_eq;
    logic                   w_hit;
    logic                   w_last;
    logic [CNT_W-1:0]       w_i_inc;
    logic [CNT_W-1:0]       w_k_inc;
    logic [CTR_W-1:0]       w_sum_inc;

    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_steer_ok  = r_feature && (r_count != '0);
    assign w_go_check  = (i_handle_length >= LONG_LEN) && (r_count != '0);
    assign w_go_find   = (i_device_id_high == ID_PREFIX) && (r_count != '0);
    assign w_reg_ok    = r_count < MAX_CNT;
    assign w_set_ok    = {1'b0, i_entry_index} < r_count;
    assign w_mod_start = w_accept && (i_req_type == REQ_STEER) && w_steer_ok;

    // Start offset of the round-robin scan: counter mod entry count
    dsts_mod_unit #(
        .DIVIDEND_W (CTR_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_counter),
        .i_divisor  (r_count),
        .o_res      (w_mod)
    );

    // Shared compare: mount id for check, device id tail for find
    assign w_sel = (r_req == REQ_STEER) ? r_k : r_i[IDX_W-1:0];
    always_comb begin
        if (r_req == REQ_CHECK) begin
            w_cmp_a = r_keys[w_sel];
            w_cmp_b = r_key;
            w_cmp_m = KEY_MASK;
        end else begin
            w_cmp_a = r_idl;
            w_cmp_b = KEY_W'(r_i) + 1'b1;
            w_cmp_m = {KEY_W{1'b1}};
        end
    end
    assign w_eq = ((w_cmp_a ^ w_cmp_b) & w_cmp_m) == '0;

    always_comb begin
        unique case (r_req)
            REQ_STEER: w_hit = r_ready[w_sel];
            REQ_CHECK: w_hit = r_long[w_sel] && w_eq;
            REQ_FIND:  w_hit = w_eq;
            default:   w_hit = 1'b0;
        endcase
    end

    assign w_i_inc   = r_i + 1'b1;
    assign w_last    = w_i_inc == r_count;
    assign w_k_inc   = {1'b0, r_k} + 1'b1;
    assign w_sum_inc = r_sum + 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if ((i_req_type == REQ_STEER) && w_steer_ok) begin
                        n_state = ST_MOD;
                    end else if ((i_req_type == REQ_CHECK) && w_go_check) begin
                        n_state = ST_SCAN;
                    end else if ((i_req_type == REQ_FIND) && w_go_find) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_MOD: begin
                if (w_mod.done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and result values
    always_comb begin
        n_count     = r_count;
        n_counter   = r_counter;
        n_k         = r_k;
        n_i         = r_i;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_rindex    = r_rindex;
        n_hit       = r_hit;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = STATUS_IGNORED;
                    n_rindex    = '0;
                    n_hit       = 1'b0;
                    unique case (i_req_type)
                        REQ_REGISTER: begin
                            if (w_reg_ok) begin
                                n_count  = r_count + 1'b1;
                                n_status = STATUS_OK;
                                n_rindex = r_count[IDX_W-1:0];
                            end
                        end
                        REQ_SET_ROOT: begin
                            if (w_set_ok) begin
                                n_status = STATUS_OK;
                                n_rindex = i_entry_index;
                            end
                        end
                        REQ_STEER: begin
                            n_status = STATUS_NONE;
                            if (w_steer_ok) begin
                                n_out_valid = 1'b0;
                                n_counter   = r_counter + 1'b1;
                                n_sum       = r_counter;
                            end
                        end
                        REQ_CHECK: begin
                            n_status = STATUS_OK;
                            if (w_go_check) begin
                                n_out_valid = 1'b0;
                                n_i         = '0;
                            end
                        end
                        REQ_FIND: begin
                            n_status = STATUS_NONE;
                            if (w_go_find) begin
                                n_out_valid = 1'b0;
                                n_i         = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD: begin
                if (w_mod.done) begin
                    n_k = w_mod.remainder[IDX_W-1:0];
                    n_i = '0;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_out_valid = 1'b1;
                    n_status    = STATUS_OK;
                    n_rindex    = (r_req == REQ_CHECK) ? '0 : w_sel;
                    n_hit       = r_req == REQ_CHECK;
                end else if (w_last) begin
                    n_out_valid = 1'b1;
                    n_status    = (r_req == REQ_CHECK) ? STATUS_OK : STATUS_NONE;
                    n_rindex    = '0;
                    n_hit       = 1'b0;
                end else begin
                    n_i   = w_i_inc;
                    n_sum = w_sum_inc;
                    // Restart at entry zero when the 32-bit sum wraps
                    if (w_sum_inc == '0) begin
                        n_k = '0;
                    end else if (w_k_inc == r_count) begin
                        n_k = '0;
                    end else begin
                        n_k = w_k_inc[IDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        n_used   = n_count;
        n_active = r_feature && (n_count != '0);
    end

    // Control registers and ready/long flags of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_counter   <= '0;
            r_ready     <= '0;
            r_long      <= '0;
            r_feature   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_feature <= i_cfg_feature_on;
            end
            if (w_accept && (i_req_type == REQ_REGISTER) && w_reg_ok) begin
                r_ready[r_count[IDX_W-1:0]] <= 1'b0;
                r_long[r_count[IDX_W-1:0]]  <= 1'b0;
            end
            if (w_accept && (i_req_type == REQ_SET_ROOT) && w_set_ok) begin
                r_ready[i_entry_index] <= i_handle_length != '0;
                r_long[i_entry_index]  <= i_handle_length >= LONG_LEN;
            end
        end
    end

    // Payload registers: mount keys, captured request, scan state, result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_key <= i_mount_key;
            r_idl <= i_device_id_low;
        end
        if (w_accept && (i_req_type == REQ_SET_ROOT) && w_set_ok) begin
            r_keys[i_entry_index] <= i_mount_key;
        end
        r_k      <= n_k;
        r_i      <= n_i;
        r_sum    <= n_sum;
        r_status <= n_status;
        r_rindex <= n_rindex;
        r_hit    <= n_hit;
        r_used   <= n_used;
        r_active <= n_active;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_result_index   = r_rindex;
    assign o_backing_hit    = r_hit;
    assign o_entries_used   = r_used;
    assign o_service_active = r_active;

endmodule

@@ rtl/dsts_mod_unit.sv @@
// Bit-serial restoring modulo: dividend mod divisor, one dividend bit per cycle.
// Depends on dsts_pkg (CNT_W, t_mod_res).
module dsts_mod_unit #(
    parameter int DIVIDEND_W = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIVIDEND_W-1:0]     i_dividend,
    input  logic [dsts_pkg::CNT_W-1:0] i_divisor,
    output dsts_pkg::t_mod_res        o_res
);
    import dsts_pkg::*;

    localparam int BITS_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_dvd;
    logic [CNT_W-1:0]      r_div;
    logic [CNT_W-1:0]      r_rem;
    logic [BITS_W-1:0]     r_bits;
    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W:0]        w_trial;
    logic [CNT_W:0]        w_diff;

    // Shift in the next dividend bit and try to subtract the divisor
    assign w_trial = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    // Control: busy while bits remain, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bits <= BITS_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_bits <= r_bits - 1'b1;
                if (r_bits == BITS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= w_diff[CNT_W-1:0];
            end else begin
                r_rem <= w_trial[CNT_W-1:0];
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.remainder = r_rem;

endmodule

@@ rtl/dsts_checker.sv @@
// Port-level checks for the data server table steering block, bound to its top level.
// Depends only on the top level's ports.
module dsts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [3:0]  o_result_index,
    input logic        o_backing_hit,
    input logic [4:0]  o_entries_used,
    input logic        o_service_active
);

    // A request is never taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request ready while a result is pending");

    // One request at a time: ready drops after a request transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a request transfer");

    // An active service in a presented result implies at least one registered server
    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_service_active) |-> (o_entries_used != 5'd0))
        else $error("service active with an empty table");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_result_index) && $stable(o_backing_hit)))
        else $error("stalled result changed");

endmodule

bind data_server_table_steering_top dsts_checker u_dsts_checker (.*);

@@ tb/dsts_reply_checker.sv @@
`timescale 1ns / 1ps
// Reply checker for the data server table steering block: mirrors the server table,
// predicts the reply to each request transfer and compares it with each reply transfer.
// Depends on dsts_pkg.
module dsts_reply_checker #(
    parameter int MOUNT_ID_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [dsts_pkg::REQ_W-1:0]    i_req_type,
    input  logic [dsts_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [dsts_pkg::LEN_W-1:0]    i_handle_length,
    input  logic [dsts_pkg::KEY_W-1:0]    i_mount_key,
    input  logic [dsts_pkg::KEY_W-1:0]    i_device_id_high,
    input  logic [dsts_pkg::KEY_W-1:0]    i_device_id_low,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [dsts_pkg::STATUS_W-1:0] i_status,
    input  logic [dsts_pkg::IDX_W-1:0]    i_result_index,
    input  logic                          i_backing_hit,
    input  logic [dsts_pkg::CNT_W-1:0]    i_entries_used,
    input  logic                          i_service_active,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic                          i_cfg_feature_on,
    output int                            o_fail_count,
    output int                            o_replies_seen
);
    import dsts_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic             hit;
        logic [CNT_W-1:0] used;
        logic             active;
    } t_reply;

    // Only the top MOUNT_ID_BYTES bytes of a key take part in the mount id compare
    localparam logic [KEY_W-1:0] MOUNT_MASK = (MOUNT_ID_BYTES >= 8) ? {KEY_W{1'b1}} :
        ({KEY_W{1'b1}} << (KEY_W - 8 * MOUNT_ID_BYTES));

    // Mirror of the server table
    logic             feature_on;
    logic [CNT_W-1:0] server_count;
    logic [CTR_W-1:0] rotate_ctr;
    logic [LEN_W-1:0] root_len [MAX_DEVICES];
    logic [KEY_W-1:0] mount_id [MAX_DEVICES];

    t_reply pending_replies [$];
    t_reply want_reply;

    // Apply one request to the mirror and return the reply it produces
    function automatic t_reply predict_reply(
        input logic [REQ_W-1:0] req,
        input logic [IDX_W-1:0] idx,
        input logic [LEN_W-1:0] len,
        input logic [KEY_W-1:0] key,
        input logic [KEY_W-1:0] idh,
        input logic [KEY_W-1:0] idl
    );
        t_reply           r;
        logic [CTR_W-1:0] start;
        logic [CTR_W-1:0] slot;
        logic [CTR_W-1:0] cnt_w;
        logic [KEY_W-1:0] dev_low;
        logic             found;
        int               i;
        r.status = STATUS_IGNORED;
        r.index  = '0;
        r.hit    = 1'b0;
        found    = 1'b0;
        case (req)
            REQ_REGISTER: begin
                if (server_count < MAX_DEVICES) begin
                    r.index = server_count[IDX_W-1:0];
                    root_len[server_count[IDX_W-1:0]] = '0;
                    server_count = server_count + 1'b1;
                    r.status = STATUS_OK;
                end
            end
            REQ_SET_ROOT: begin
                if (idx < server_count) begin
                    root_len[idx] = len;
                    mount_id[idx] = key;
                    r.index = idx;
                    r.status = STATUS_OK;
                end
            end
            REQ_STEER: begin
                r.status = STATUS_NONE;
                if (feature_on && server_count != 0) begin
                    // Advance the rotation, scan from the old counter value onward
                    start = rotate_ctr;
                    rotate_ctr = rotate_ctr + 1'b1;
                    cnt_w = CTR_W'(server_count);
                    for (i = 0; i < server_count && !found; i++) begin
                        slot = start + CTR_W'(i);
                        slot = slot % cnt_w;
                        if (root_len[slot[IDX_W-1:0]] != 0) begin
                            found = 1'b1;
                            r.index = slot[IDX_W-1:0];
                            r.status = STATUS_OK;
                        end
                    end
                end
            end
            REQ_CHECK: begin
                r.status = STATUS_OK;
                if (len >= MOUNT_ID_BYTES) begin
                    for (i = 0; i < server_count && !found; i++) begin
                        if (root_len[i] >= MOUNT_ID_BYTES &&
                            ((mount_id[i] ^ key) & MOUNT_MASK) == '0) begin
                            found = 1'b1;
                            r.hit = 1'b1;
                        end
                    end
                end
            end
            REQ_FIND: begin
                r.status = STATUS_NONE;
                if (idh == ID_PREFIX) begin
                    for (i = 0; i < server_count && !found; i++) begin
                        dev_low = KEY_W'((i + 1) & 8'hFF);
                        if (idl == dev_low) begin
                            found = 1'b1;
                            r.index = i[IDX_W-1:0];
                            r.status = STATUS_OK;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.used   = server_count;
        r.active = feature_on && server_count != 0;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    // Track config, reply and request transfers; replies are matched before new requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            feature_on   = 1'b0;
            server_count = '0;
            rotate_ctr   = '0;
            for (int k = 0; k < MAX_DEVICES; k++) begin
                root_len[k] = '0;
                mount_id[k] = '0;
            end
            pending_replies.delete();
            o_fail_count = 0;
            o_replies_seen <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                feature_on = i_cfg_feature_on;
            if (i_out_valid && i_out_ready) begin
                o_replies_seen <= o_replies_seen + 1;
                if (pending_replies.size() == 0) begin
                    $display("%0t: reply transfer with none outstanding, status %0d index %0d",
                             $time, i_status, i_result_index);
                    o_fail_count++;
                end else begin
                    want_reply = pending_replies.pop_front();
                    check_field("status", 64'(want_reply.status), 64'(i_status));
                    check_field("result_index", 64'(want_reply.index),
                                64'(i_result_index));
                    check_field("backing_hit", 64'(want_reply.hit), 64'(i_backing_hit));
                    check_field("entries_used", 64'(want_reply.used),
                                64'(i_entries_used));
                    check_field("service_active", 64'(want_reply.active),
                                64'(i_service_active));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_replies.push_back(predict_reply(i_req_type, i_entry_index,
                    i_handle_length, i_mount_key, i_device_id_high, i_device_id_low));
        end
    end

endmodule

@@ tb/data_server_table_steering_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the data server table steering block: directed and random requests,
// feature gate changes between phases, random stalls; verdict from dsts_reply_checker.
// Depends on dsts_pkg, data_server_table_steering_top and dsts_reply_checker.
module data_server_table_steering_top_tb;
    import dsts_pkg::*;

    localparam int MOUNT_ID_BYTES = 8;
    localparam int PHASE_ITEMS    = 120;
    localparam int TAIL_CYCLES    = 60;
    localparam logic [REQ_W-1:0] REQ_LAST_CODE = {REQ_W{1'b1}};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [REQ_W-1:0]    i_req_type;
    logic [IDX_W-1:0]    i_entry_index;
    logic [LEN_W-1:0]    i_handle_length;
    logic [KEY_W-1:0]    i_mount_key;
    logic [KEY_W-1:0]    i_device_id_high;
    logic [KEY_W-1:0]    i_device_id_low;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_result_index;
    logic                o_backing_hit;
    logic [CNT_W-1:0]    o_entries_used;
    logic                o_service_active;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_feature_on;

    bit idle_on    = 1'b1;
    int stall_left = 0;
    int items_sent;
    int servers_registered;
    int fail_count;
    int replies_seen;
    logic [KEY_W-1:0] key_pool [4];
    bit phase_feature [5] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    data_server_table_steering_top #(
        .MOUNT_ID_BYTES(MOUNT_ID_BYTES)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_entry_index(i_entry_index),
        .i_handle_length(i_handle_length), .i_mount_key(i_mount_key),
        .i_device_id_high(i_device_id_high), .i_device_id_low(i_device_id_low),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_result_index(o_result_index),
        .o_backing_hit(o_backing_hit), .o_entries_used(o_entries_used),
        .o_service_active(o_service_active),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_feature_on(i_cfg_feature_on)
    );

    dsts_reply_checker #(
        .MOUNT_ID_BYTES(MOUNT_ID_BYTES)
    ) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_entry_index(i_entry_index),
        .i_handle_length(i_handle_length), .i_mount_key(i_mount_key),
        .i_device_id_high(i_device_id_high), .i_device_id_low(i_device_id_low),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(o_status), .i_result_index(o_result_index),
        .i_backing_hit(o_backing_hit), .i_entries_used(o_entries_used),
        .i_service_active(o_service_active),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_feature_on(i_cfg_feature_on),
        .o_fail_count(fail_count), .o_replies_seen(replies_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("data_server_table_steering_top_tb: FAIL");
        $finish;
    end

    // Stall the reply side in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one request, hold it until the transfer
    task automatic send_request(
        input logic [REQ_W-1:0] req,
        input logic [IDX_W-1:0] idx,
        input logic [LEN_W-1:0] len,
        input logic [KEY_W-1:0] key,
        input logic [KEY_W-1:0] idh,
        input logic [KEY_W-1:0] idl
    );
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= req;
        i_entry_index    <= idx;
        i_handle_length  <= len;
        i_mount_key      <= key;
        i_device_id_high <= idh;
        i_device_id_low  <= idl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (req == REQ_REGISTER && servers_registered < MAX_DEVICES)
            servers_registered++;
    endtask

    // Drop valid and wait until every reply has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (replies_seen != items_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_feature(input bit value);
        wait_drained();
        i_cfg_valid      <= 1'b1;
        i_cfg_feature_on <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed requests against registered servers, some noise
    task automatic random_request();
        int               roll;
        int               pick;
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] idh;
        logic [KEY_W-1:0] idl;
        roll = $urandom_range(0, 99);
        idx  = IDX_W'($urandom);
        len  = LEN_W'($urandom);
        key  = rand64();
        idh  = rand64();
        idl  = rand64();
        if (roll < 6) begin
            req = REQ_REGISTER;
        end else if (roll < 30) begin
            req = REQ_SET_ROOT;
            if (servers_registered > 0 && $urandom_range(0, 99) < 85)
                idx = IDX_W'($urandom_range(0, servers_registered - 1));
            pick = $urandom_range(0, 9);
            if (pick < 1)
                len = '0;
            else if (pick < 3)
                len = LEN_W'($urandom_range(1, MOUNT_ID_BYTES - 1));
            else if (pick < 5)
                len = LEN_W'(MOUNT_ID_BYTES);
            else if (pick < 6)
                len = 8'd128;
            if ($urandom_range(0, 9) < 6)
                key = key_pool[$urandom_range(0, 3)];
        end else if (roll < 55) begin
            req = REQ_STEER;
        end else if (roll < 75) begin
            req = REQ_CHECK;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                len = LEN_W'(MOUNT_ID_BYTES - 1);
            else if (pick < 5)
                len = LEN_W'(MOUNT_ID_BYTES);
            else if (pick < 7)
                len = 8'd128;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                key = key_pool[$urandom_range(0, 3)];
            else if (pick < 8)
                key = key_pool[$urandom_range(0, 3)] ^ (64'd1 << $urandom_range(0, 63));
        end else if (roll < 92) begin
            req = REQ_FIND;
            pick = $urandom_range(0, 9);
            if (pick < 8)
                idh = ID_PREFIX;
            else if (pick < 9)
                idh = ID_PREFIX ^ (64'd1 << $urandom_range(0, 63));
            if ($urandom_range(0, 9) < 8)
                idl = KEY_W'($urandom_range(1, MAX_DEVICES + 1));
        end else begin
            req = REQ_W'($urandom_range(REQ_FIND + 1, REQ_LAST_CODE));
        end
        send_request(req, idx, len, key, idh, idl);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_req_type       <= '0;
        i_entry_index    <= '0;
        i_handle_length  <= '0;
        i_mount_key      <= '0;
        i_device_id_high <= '0;
        i_device_id_low  <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_feature_on <= 1'b0;
        items_sent         = 0;
        servers_registered = 0;
        for (int k = 0; k < 4; k++)
            key_pool[k] = rand64();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table with the feature gate at its reset value, then a first registration
        send_request(REQ_STEER, '0, '0, '0, '0, '0);
        send_request(REQ_CHECK, '1, '1, '1, '0, '0);
        send_request(REQ_FIND, '0, '0, '0, ID_PREFIX, 64'd1);
        send_request(REQ_SET_ROOT, '0, LEN_W'(MOUNT_ID_BYTES), key_pool[0], '0, '0);
        for (int code = REQ_FIND + 1; code <= REQ_LAST_CODE; code++)
            send_request(REQ_W'(code), '1, '1, '1, '1, '1);
        send_request(REQ_REGISTER, '1, '1, '1, '1, '1);
        send_request(REQ_STEER, '0, '0, '0, '0, '0);

        // Enable steering; first steer finds no ready server
        write_feature(1'b1);
        send_request(REQ_STEER, '0, '0, '0, '0, '0);
        send_request(REQ_SET_ROOT, '0, LEN_W'(MOUNT_ID_BYTES), key_pool[0], '0, '0);
        send_request(REQ_STEER, '0, '0, '0, '0, '0);
        send_request(REQ_CHECK, '0, LEN_W'(MOUNT_ID_BYTES - 1), key_pool[0], '0, '0);
        send_request(REQ_CHECK, '0, LEN_W'(MOUNT_ID_BYTES), key_pool[0], '0, '0);
        send_request(REQ_CHECK, '0, LEN_W'(MOUNT_ID_BYTES), key_pool[0] ^ 64'd1, '0, '0);
        send_request(REQ_REGISTER, '0, '0, '0, '0, '0);
        send_request(REQ_SET_ROOT, 4'd1, LEN_W'(MOUNT_ID_BYTES - 1), '1, '0, '0);
        send_request(REQ_CHECK, '0, 8'd128, '1, '0, '0);
        send_request(REQ_FIND, '0, '0, '0, ID_PREFIX, 64'd2);
        send_request(REQ_FIND, '0, '0, '0, ID_PREFIX, 64'd3);
        send_request(REQ_FIND, '0, '0, '0, ID_PREFIX ^ (64'd1 << 63), 64'd1);
        send_request(REQ_SET_ROOT, '1, '1, '1, '0, '0);
        send_request(REQ_STEER, '0, '0, '0, '0, '0);
        send_request(REQ_STEER, '0, '0, '0, '0, '0);

        // Random phases under the feature gate settings listed in phase_feature
        foreach (phase_feature[p]) begin
            write_feature(phase_feature[p]);
            repeat (PHASE_ITEMS) random_request();
        end

        // Fill the table, then hit it once more while full
        write_feature(1'b1);
        while (servers_registered < MAX_DEVICES)
            send_request(REQ_REGISTER, IDX_W'($urandom), LEN_W'($urandom), rand64(),
                         rand64(), rand64());
        send_request(REQ_REGISTER, IDX_W'($urandom), LEN_W'($urandom), rand64(),
                     rand64(), rand64());

        // Last stretch without idling on either side
        idle_on = 1'b0;
        repeat (PHASE_ITEMS) random_request();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && replies_seen == items_sent)
            $display("data_server_table_steering_top_tb: PASS");
        else
            $display("data_server_table_steering_top_tb: FAIL");
        $finish;
    end

endmodule
